### hw/rtl/ltfc_pkg.sv
// shared types and constants of the length trailer frame checker
package ltfc_pkg;

  // default payload limit before an overflow flush
  localparam int unsigned MaxPayloadDef = 128;

  // width of the decoded length text value
  localparam int unsigned LenW = 10;

  // result queue depth
  localparam int unsigned FifoDepth = 4;
  localparam int unsigned PtrW      = $clog2(FifoDepth);
  localparam int unsigned FcntW     = $clog2(FifoDepth + 1);

  // framing characters
  localparam logic [7:0] ChLf    = 8'h0A;
  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;

  // result kinds
  typedef enum logic [1:0] {
    KIND_DATA  = 2'd0,
    KIND_END   = 2'd1,
    KIND_FLUSH = 2'd2
  } kind_e;

  // one result item
  typedef struct packed {
    kind_e       kind;
    logic [7:0]  data_byte;
    logic        frame_ok;
    logic [7:0]  payload_length;
    logic        last;
  } result_t;

endpackage

### hw/rtl/length_trailer_frame_checker.sv
// length trailer frame checker: byte receive, length check and result queue
//
// Input channel: one received byte per item on rx_byte_i, accepted at a rising
// edge with in_valid_i high and in_stall_o low. Frames are payload bytes, CR,
// a decimal length, LF. Each accepted byte gives zero, one or two result items
// (flush of an overflowed payload, payload data, or frame end verdict), with
// last_o marking the final result of that byte.
// Output channel: result items leave a 4-entry queue, taken at a rising edge
// with out_valid_o high and out_stall_i low. out_valid_o never looks at
// out_stall_i.
// Results are registered: each is written into the queue at the edge that accepts its byte.
// Throughput: one byte per cycle while in_stall_o is low; the byte decode is one
// compare, a counter and a decimal multiply-add between the input port and the
// queue registers. The input stalls while the queue has fewer than two free entries.
// Configuration: cfg_we_i writes cfg_data_i into the observable bit; while it
// is zero every byte is accepted and dropped with no effect.
// Reset: observable is set, frame state is cleared and the queue is empty.
// A stalled receiver only fills the queue; state advances only on accepts.
module length_trailer_frame_checker #(
  parameter int unsigned MAX_PAYLOAD = ltfc_pkg::MaxPayloadDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_data_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] rx_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [1:0] kind_o,
  output logic [7:0] data_byte_o,
  output logic       frame_ok_o,
  output logic [7:0] payload_length_o,
  output logic       last_o
);
  import ltfc_pkg::*;

  localparam int unsigned CntW = $clog2(MAX_PAYLOAD + 1);
  localparam int unsigned CmpW = (CntW + 1 > LenW) ? CntW + 1 : LenW;

  // state
  logic            observable_q;
  logic [CntW-1:0] payload_count_q, payload_count_d;
  logic            length_phase_q, length_phase_d;
  logic [LenW-1:0] length_value_q, length_value_d;
  logic [1:0]      length_digits_q, length_digits_d;
  logic            length_bad_q, length_bad_d;

  // result queue
  result_t         fifo_q [FifoDepth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [FcntW-1:0] fcnt_q;

  logic            accept, work, pop;
  logic            flush, is_lf, is_cr, is_data, is_len, has_main;
  logic            is_digit, len_reject;
  logic [3:0]      digit;
  logic [CntW-1:0] cnt0;
  logic            frame_ok;
  logic            push0, push1;
  logic [1:0]      push_n;
  result_t         flush_res, main_res, e0, e1;

  // handshakes
  assign in_stall_o  = fcnt_q > FcntW'(FifoDepth - 2);
  assign accept      = in_valid_i && !in_stall_o;
  assign work        = accept && observable_q;
  assign out_valid_o = fcnt_q != '0;
  assign pop         = out_valid_o && !out_stall_i;

  // byte classification
  assign flush    = payload_count_q >= CntW'(MAX_PAYLOAD);
  assign cnt0     = flush ? '0 : payload_count_q;
  assign is_lf    = rx_byte_i == ChLf;
  assign is_cr    = rx_byte_i == ChCr;
  assign is_data  = !is_lf && !is_cr && !length_phase_q;
  assign is_len   = !is_lf && !is_cr && length_phase_q;
  assign has_main = is_lf || is_data;

  // length text digit check
  assign is_digit   = (rx_byte_i >= ChZero) && (rx_byte_i <= ChNine);
  assign digit      = 4'(rx_byte_i - ChZero);
  assign len_reject = !is_digit || (length_digits_q == 2'd3) ||
                      (length_digits_q == 2'd0 && digit == 4'd0);

  // frame verdict against count plus one
  assign frame_ok = (length_digits_q != 2'd0) && !length_bad_q &&
                    (CmpW'(length_value_q) == CmpW'(cnt0) + CmpW'(1));

  // result items
  always_comb begin
    flush_res.kind           = KIND_FLUSH;
    flush_res.data_byte      = '0;
    flush_res.frame_ok       = 1'b0;
    flush_res.payload_length = 8'(payload_count_q);
    flush_res.last           = !has_main;
    if (is_lf) begin
      main_res.kind           = KIND_END;
      main_res.data_byte      = '0;
      main_res.frame_ok       = frame_ok;
      main_res.payload_length = 8'(cnt0);
    end else begin
      main_res.kind           = KIND_DATA;
      main_res.data_byte      = rx_byte_i;
      main_res.frame_ok       = 1'b0;
      main_res.payload_length = '0;
    end
    main_res.last = 1'b1;
    e0     = flush ? flush_res : main_res;
    e1     = main_res;
    push0  = work && (flush || has_main);
    push1  = work && flush && has_main;
    push_n = {1'b0, push0} + {1'b0, push1};
  end

  // next frame state
  always_comb begin
    payload_count_d = payload_count_q;
    length_phase_d  = length_phase_q;
    length_value_d  = length_value_q;
    length_digits_d = length_digits_q;
    length_bad_d    = length_bad_q;
    if (work) begin
      payload_count_d = cnt0;
      if (is_lf) begin
        payload_count_d = '0;
        length_phase_d  = 1'b0;
        length_value_d  = '0;
        length_digits_d = '0;
        length_bad_d    = 1'b0;
      end else if (is_cr) begin
        length_phase_d = 1'b1;
      end else if (is_len) begin
        if (!length_bad_q) begin
          if (len_reject) begin
            length_bad_d = 1'b1;
          end else begin
            length_value_d  = length_value_q * LenW'(10) + LenW'(digit);
            length_digits_d = length_digits_q + 2'd1;
          end
        end
      end else begin
        payload_count_d = cnt0 + CntW'(1);
      end
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      observable_q    <= 1'b1;
      payload_count_q <= '0;
      length_phase_q  <= 1'b0;
      length_value_q  <= '0;
      length_digits_q <= '0;
      length_bad_q    <= 1'b0;
      wr_ptr_q        <= '0;
      rd_ptr_q        <= '0;
      fcnt_q          <= '0;
    end else begin
      if (cfg_we_i) begin
        observable_q <= cfg_data_i;
      end
      payload_count_q <= payload_count_d;
      length_phase_q  <= length_phase_d;
      length_value_q  <= length_value_d;
      length_digits_q <= length_digits_d;
      length_bad_q    <= length_bad_d;
      wr_ptr_q        <= wr_ptr_q + PtrW'(push_n);
      rd_ptr_q        <= rd_ptr_q + PtrW'(pop);
      fcnt_q          <= fcnt_q + FcntW'(push_n) - FcntW'(pop);
    end
  end

  // queue storage
  always_ff @(posedge clk_i) begin
    if (push0) begin
      fifo_q[wr_ptr_q] <= e0;
    end
    if (push1) begin
      fifo_q[wr_ptr_q + PtrW'(1)] <= e1;
    end
  end

  // head of queue
  assign kind_o           = fifo_q[rd_ptr_q].kind;
  assign data_byte_o      = fifo_q[rd_ptr_q].data_byte;
  assign frame_ok_o       = fifo_q[rd_ptr_q].frame_ok;
  assign payload_length_o = fifo_q[rd_ptr_q].payload_length;
  assign last_o           = fifo_q[rd_ptr_q].last;

endmodule

### hw/rtl/ltfc_checker.sv
// port checker for the length trailer frame checker, bound to the top level
module ltfc_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [1:0] kind_o,
  input logic [7:0] data_byte_o,
  input logic       frame_ok_o,
  input logic [7:0] payload_length_o,
  input logic       last_o
);
  import ltfc_pkg::*;

  // queue is empty while in reset
  assert property (@(posedge clk_i) !rst_ni |-> !out_valid_o)
    else $error("result valid during reset");

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(kind_o) &&
    $stable(data_byte_o) && $stable(payload_length_o) && $stable(last_o))
    else $error("stalled result changed");

  // a data result is always the final one of its byte and carries no length
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == KIND_DATA |->
    last_o && payload_length_o == 8'd0 && !frame_ok_o)
    else $error("bad data result");

  // non-data results carry a zero byte, verdict only on frame end
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o != KIND_DATA |->
    data_byte_o == 8'd0 && (kind_o == KIND_END || !frame_ok_o))
    else $error("bad end or flush result");

  // only the defined kinds appear
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> kind_o == KIND_DATA || kind_o == KIND_END || kind_o == KIND_FLUSH)
    else $error("undefined result kind");

endmodule

bind length_trailer_frame_checker ltfc_checker u_ltfc_checker (.*);

### dv/ltfc_result_checker.sv
// result checker for the length trailer frame checker: predicts and compares results
`timescale 1ns / 1ps

module ltfc_result_checker
  import ltfc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_data_i,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [7:0]  rx_byte_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [1:0]  kind_i,
  input  logic [7:0]  data_byte_i,
  input  logic        frame_ok_i,
  input  logic [7:0]  payload_length_i,
  input  logic        last_i,
  output int unsigned mismatch_cnt_o,
  output int unsigned owed_cnt_o
);

  localparam int unsigned PayloadLimit = MaxPayloadDef;

  // mirrored frame state
  logic        observable;
  int unsigned payload_count;
  logic        in_length_text;
  int unsigned length_value;
  int unsigned length_digits;
  logic        length_bad;

  // results the block still owes, oldest first
  result_t     owed_results[$];

  // compare one field, report on a difference
  task automatic compare_field(input string what, input logic [7:0] want,
                               input logic [7:0] got);
    if (want !== got) begin
      $display("%0t ns: %s mismatch, expected 0x%02h, actual 0x%02h",
               $time, what, want, got);
      mismatch_cnt_o++;
    end
  endtask

  // work out the results of one accepted byte and queue them
  task automatic predict_byte(input logic [7:0] rx);
    result_t made [2];
    int      n;
    logic    verdict;
    n = 0;
    // overflowed payload is flushed before the byte is looked at
    if (payload_count >= PayloadLimit) begin
      made[n] = '{kind: KIND_FLUSH, data_byte: 8'h00, frame_ok: 1'b0,
                  payload_length: 8'(payload_count), last: 1'b0};
      n++;
      payload_count = 0;
    end
    if (rx == ChLf) begin
      // frame end: length text must be canonical count plus one
      verdict = (length_digits != 0) && !length_bad &&
                (length_value == payload_count + 1);
      made[n] = '{kind: KIND_END, data_byte: 8'h00, frame_ok: verdict,
                  payload_length: 8'(payload_count), last: 1'b0};
      n++;
      payload_count  = 0;
      in_length_text = 1'b0;
      length_value   = 0;
      length_digits  = 0;
      length_bad     = 1'b0;
    end else if (rx == ChCr) begin
      in_length_text = 1'b1;
    end else if (in_length_text) begin
      // decimal text: digits only, no leading zero, three digits at most
      if (!length_bad) begin
        if (rx < ChZero || rx > ChNine) begin
          length_bad = 1'b1;
        end else if (length_digits >= 3 || (length_digits == 0 && rx == ChZero)) begin
          length_bad = 1'b1;
        end else begin
          length_value = (length_value * 10 + (rx - ChZero)) & 32'h3FF;
          length_digits++;
        end
      end
    end else begin
      made[n] = '{kind: KIND_DATA, data_byte: rx, frame_ok: 1'b0,
                  payload_length: 8'h00, last: 1'b0};
      n++;
      payload_count++;
    end
    if (n > 0) made[n-1].last = 1'b1;
    for (int k = 0; k < n; k++) owed_results.push_back(made[k]);
  endtask

  // sample both channels at the rising edge
  always @(posedge clk_i) begin : watch
    result_t want;
    if (!rst_ni) begin
      observable     = 1'b1;
      payload_count  = 0;
      in_length_text = 1'b0;
      length_value   = 0;
      length_digits  = 0;
      length_bad     = 1'b0;
      owed_results.delete();
    end else begin
      // result taken at this edge against the oldest owed one
      if (out_valid_i && !out_stall_i) begin
        if (owed_results.size() == 0) begin
          $display("%0t ns: unexpected result, expected none, actual kind %0d data 0x%02h",
                   $time, kind_i, data_byte_i);
          mismatch_cnt_o++;
        end else begin
          want = owed_results.pop_front();
          compare_field("kind", 8'(want.kind), 8'(kind_i));
          compare_field("data_byte", want.data_byte, data_byte_i);
          compare_field("frame_ok", 8'(want.frame_ok), 8'(frame_ok_i));
          compare_field("payload_length", want.payload_length, payload_length_i);
          compare_field("last", 8'(want.last), 8'(last_i));
        end
      end
      // byte accepted at this edge
      if (in_valid_i && !in_stall_i && observable) predict_byte(rx_byte_i);
      if (cfg_we_i) observable = cfg_data_i;
    end
    owed_cnt_o = owed_results.size();
  end

endmodule

### dv/tb_length_trailer_frame_checker.sv
// testbench top for the length trailer frame checker: stimulus, back-pressure and verdict
`timescale 1ns / 1ps

module tb_length_trailer_frame_checker;
  import ltfc_pkg::*;

  localparam int unsigned CycleLimit   = 300000;
  localparam int unsigned ItemTarget   = 750;
  localparam int unsigned PayloadLimit = MaxPayloadDef;

  // kinds of length trailer the random frames carry
  typedef enum int {
    TRAILER_GOOD,
    TRAILER_OFF_BY_ONE,
    TRAILER_LEADING_ZERO,
    TRAILER_FOUR_DIGITS,
    TRAILER_NON_DIGIT,
    TRAILER_EMPTY,
    TRAILER_NO_CR,
    TRAILER_EXTRA_CR
  } trailer_e;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        cfg_we_i    = 1'b0;
  logic        cfg_data_i  = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic [7:0]  rx_byte_i   = 8'h00;
  logic        out_stall_i = 1'b0;
  logic        in_stall_o;
  logic        out_valid_o;
  logic [1:0]  kind_o;
  logic [7:0]  data_byte_o;
  logic        frame_ok_o;
  logic [7:0]  payload_length_o;
  logic        last_o;

  int unsigned mismatch_cnt;
  int unsigned owed_cnt;
  int unsigned bytes_counted = 0;
  int unsigned cycle_cnt     = 0;
  int unsigned stall_left    = 0;
  logic        listening     = 1'b1;
  logic        no_gaps       = 1'b0;
  logic        result_taken  = 1'b0;

  always #6 clk_i = ~clk_i;

  length_trailer_frame_checker dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .rx_byte_i        (rx_byte_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .kind_o           (kind_o),
    .data_byte_o      (data_byte_o),
    .frame_ok_o       (frame_ok_o),
    .payload_length_o (payload_length_o),
    .last_o           (last_o)
  );

  ltfc_result_checker result_check (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_stall_i       (in_stall_o),
    .rx_byte_i        (rx_byte_i),
    .out_valid_i      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .kind_i           (kind_o),
    .data_byte_i      (data_byte_o),
    .frame_ok_i       (frame_ok_o),
    .payload_length_i (payload_length_o),
    .last_i           (last_o),
    .mismatch_cnt_o   (mismatch_cnt),
    .owed_cnt_o       (owed_cnt)
  );

  // receiver back-pressure: each result waits a drawn number of cycles
  always @(posedge clk_i) result_taken <= out_valid_o && !out_stall_i;

  always @(negedge clk_i) begin
    if (result_taken) stall_left = no_gaps ? 0 : $urandom_range(0, 6);
    out_stall_i = (stall_left != 0);
    if (stall_left != 0) stall_left--;
  end

  // offer one byte after a drawn gap and hold it until taken
  task automatic send_byte(input logic [7:0] value);
    int unsigned gap;
    gap = no_gaps ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      @(negedge clk_i);
      in_valid_i = 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i = 1'b1;
    rx_byte_i  = value;
    do @(posedge clk_i); while (in_stall_o);
    if (listening) bytes_counted++;
  endtask

  task automatic send_text(input string s);
    for (int k = 0; k < s.len(); k++) send_byte(s[k]);
  endtask

  // stop sending until every owed result is out, then let the block settle
  task automatic wait_drained(input int unsigned settle);
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (owed_cnt != 0) @(negedge clk_i);
    repeat (settle) @(negedge clk_i);
  endtask

  task automatic write_observable(input logic value);
    wait_drained(4);
    cfg_we_i   = 1'b1;
    cfg_data_i = value;
    @(negedge clk_i);
    cfg_we_i   = 1'b0;
    listening  = value;
  endtask

  // one frame with random payload and a mostly well-formed length trailer
  task automatic send_random_frame(input bit go_long);
    int unsigned body_len;
    int unsigned kept;
    int unsigned target;
    int unsigned r;
    trailer_e    shape;
    logic [7:0]  text[$];
    logic [7:0]  b;
    no_gaps = ($urandom_range(0, 9) == 0);
    // stray byte between frames
    if ($urandom_range(0, 15) == 0) send_byte(8'($urandom_range(0, 255)));
    body_len = (go_long || $urandom_range(0, 19) == 0) ? $urandom_range(120, 260)
                                                        : $urandom_range(0, 12);
    for (int k = 0; k < body_len; k++) begin
      do b = 8'($urandom_range(0, 255)); while (b == ChCr || b == ChLf);
      send_byte(b);
    end
    // count left after overflow flushes
    kept   = body_len % PayloadLimit;
    r      = $urandom_range(0, 15);
    shape  = (r < 9) ? TRAILER_GOOD : trailer_e'(r - 8);
    target = kept + 1;
    if (shape == TRAILER_OFF_BY_ONE) target = $urandom_range(0, 1) ? kept + 2 : kept;
    if (shape == TRAILER_FOUR_DIGITS) target = $urandom_range(1000, 9999);
    if (target >= 1000) text.push_back(8'(ChZero + target / 1000));
    if (target >= 100) text.push_back(8'(ChZero + (target / 100) % 10));
    if (target >= 10) text.push_back(8'(ChZero + (target / 10) % 10));
    text.push_back(8'(ChZero + target % 10));
    case (shape)
      TRAILER_LEADING_ZERO: begin
        text.push_front(ChZero);
      end
      TRAILER_NON_DIGIT: begin
        do b = 8'($urandom_range(0, 255));
        while ((b >= ChZero && b <= ChNine) || b == ChCr || b == ChLf);
        text.insert($urandom_range(0, text.size()), b);
      end
      TRAILER_EXTRA_CR: begin
        text.insert($urandom_range(0, text.size()), ChCr);
      end
      default: ;
    endcase
    if (shape != TRAILER_NO_CR) send_byte(ChCr);
    if (shape != TRAILER_NO_CR && shape != TRAILER_EMPTY) begin
      foreach (text[k]) send_byte(text[k]);
    end
    send_byte(ChLf);
  endtask

  // watchdog
  initial begin
    while (cycle_cnt < CycleLimit) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("FAIL");
    $finish;
  end

  // stimulus and verdict
  initial begin
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    write_observable(1'b1);

    // directed frames
    send_byte(ChLf);
    send_byte(ChCr);
    send_byte(ChLf);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(ChCr);
    send_text("3");
    send_byte(ChLf);
    send_text("A");
    send_byte(ChCr);
    send_text("02");
    send_byte(ChLf);
    send_byte(ChCr);
    send_byte(ChCr);
    send_text("1");
    send_byte(ChLf);
    send_text("B");
    send_byte(ChCr);
    send_text("1000");
    send_byte(ChLf);

    // random frames, the first one long (120 to 260 payload bytes) so that it can overflow
    send_random_frame(1'b1);
    while (bytes_counted < ItemTarget / 2) begin
      send_random_frame(1'b0);
      if ($urandom_range(0, 39) == 0) wait_drained(0);
    end

    // frame interrupted by a stretch with the receiver switched off
    send_text("hello");
    write_observable(1'b0);
    repeat (40) send_byte(8'($urandom_range(0, 255)));
    write_observable(1'b1);
    send_byte(ChCr);
    send_text("6");
    send_byte(ChLf);

    while (bytes_counted < ItemTarget) begin
      send_random_frame(1'b0);
      if ($urandom_range(0, 39) == 0) wait_drained(0);
    end

    wait_drained(10);
    if (mismatch_cnt == 0 && owed_cnt == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
